@@ hdl/pwfs_pkg.sv @@
// pwfs_pkg: shared types, constants and register codes for the wall-follow steering block
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package pwfs_pkg;

	// field widths
	localparam int PROX_W     = 12;
	localparam int N_PROX     = 8;
	localparam int SPEED_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 16;
	localparam int TIME_W     = 16;
	localparam int TARGET_W   = 12;

	// internal value widths
	localparam int SUM_W   = 15;  // five times a full-scale sample
	localparam int ERR_W   = 21;  // signed q12.8 error
	localparam int INTEG_W = 40;  // signed integral
	localparam int P_W     = 36;
	localparam int D_W     = 45;
	localparam int I_W     = 61;
	localparam int DS_W    = 63;
	localparam int BASE_W  = 14;
	localparam int MAG8_W  = DS_W - 12;
	localparam int OUTS_W  = MAG8_W + 2;

	// default parameter values
	localparam int unsigned TICK_MS_DEF     = 64;
	localparam int unsigned SAMPLE_BITS_DEF = 12;

	// arithmetic constants
	localparam int unsigned WEIGHT_SUM = 5;
	localparam int unsigned AVG_ROUND  = 2;
	localparam int unsigned MS_PER_S   = 1000;
	localparam int unsigned BASE_MUL   = 3;
	localparam logic [63:0] PROD_LIMIT = 64'd1 << 52;
	localparam logic [DS_W-1:0] DS_LIMIT = DS_W'(64'd1 << 20);

	localparam logic [1:0] W_LEFT  [N_PROX] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd3};
	localparam logic [1:0] W_RIGHT [N_PROX] = '{2'd3, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};

	// configuration registers
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_K           = 3'd0,
		REG_INTEGRAL_TIME    = 3'd1,
		REG_DERIVATIVE_TIME  = 3'd2,
		REG_SPEED_MULTIPLIER = 3'd3,
		REG_DISTANCE_TARGET  = 3'd4
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0]   GAIN_K_RST           = 16'd0;
	localparam logic [TIME_W-1:0]   INTEGRAL_TIME_RST    = 16'd256;
	localparam logic [TIME_W-1:0]   DERIVATIVE_TIME_RST  = 16'd0;
	localparam logic [GAIN_W-1:0]   SPEED_MULTIPLIER_RST = 16'd4096;
	localparam logic [TARGET_W-1:0] DISTANCE_TARGET_RST  = 12'd700;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_k;
		logic [TIME_W-1:0]   integral_time;
		logic [TIME_W-1:0]   derivative_time;
		logic [GAIN_W-1:0]   speed_multiplier;
		logic [TARGET_W-1:0] distance_target;
	} cfg_t;

	// shared multiply / divide unit
	localparam int MDU_A_W      = 64;
	localparam int MDU_B_W      = 32;
	localparam int MUL_W        = 32;
	localparam int DIVISOR_W    = 16;
	localparam int DIV_STEP     = 4;  // quotient bits per cycle
	localparam int DIV_CYCLES   = MDU_A_W / DIV_STEP;
	localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

	typedef enum logic {
		MDU_MUL = 1'b0,
		MDU_DIV = 1'b1
	} mdu_op_t;

	typedef struct packed {
		logic                 start;
		mdu_op_t              op;
		logic [MDU_A_W-1:0]   a;
		logic [MDU_B_W-1:0]   b;
	} mdu_req_t;

	typedef struct packed {
		logic                 done;
		logic [MDU_A_W-1:0]   res;
	} mdu_rsp_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_INC_MUL,
		ST_INC_DIV,
		ST_P,
		ST_D_SCALE,
		ST_D_GAIN,
		ST_D_MUL,
		ST_D_DIV,
		ST_I_LO,
		ST_I_HI,
		ST_I_DIV,
		ST_SUM_PD,
		ST_SUM_I,
		ST_SCALE,
		ST_OUT
	} seq_state_t;

endpackage

@@ hdl/pwfs_in_if.sv @@
// pwfs_in_if: sample channel, eight proximity readings and the wall side flag
// depends on pwfs_pkg
`timescale 1ns / 1ps

interface pwfs_in_if;
	import pwfs_pkg::*;

	logic              valid;
	logic              ready;
	logic [PROX_W-1:0] prox_0;
	logic [PROX_W-1:0] prox_1;
	logic [PROX_W-1:0] prox_2;
	logic [PROX_W-1:0] prox_3;
	logic [PROX_W-1:0] prox_4;
	logic [PROX_W-1:0] prox_5;
	logic [PROX_W-1:0] prox_6;
	logic [PROX_W-1:0] prox_7;
	logic              wall_side;

	modport source (
		output valid, prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
			wall_side,
		input  ready
	);

	modport sink (
		input  valid, prox_0, prox_1, prox_2, prox_3, prox_4, prox_5, prox_6, prox_7,
			wall_side,
		output ready
	);

endinterface

@@ hdl/pwfs_out_if.sv @@
// pwfs_out_if: speed channel, left and right motor speeds in signed q8.8
// depends on pwfs_pkg
`timescale 1ns / 1ps

interface pwfs_out_if;
	import pwfs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;

	modport source (
		output valid, left_speed, right_speed,
		input  ready
	);

	modport sink (
		input  valid, left_speed, right_speed,
		output ready
	);

endinterface

@@ hdl/pwfs_mdu.sv @@
// pwfs_mdu: shared unsigned multiply / divide unit
// registered 32x32 multiply, or a 64 by 16 bit divide at four quotient bits a cycle; uses pwfs_pkg
`timescale 1ns / 1ps

module pwfs_mdu (
	input  logic               clk,
	input  logic               arst_n,
	input  pwfs_pkg::mdu_req_t req,
	output pwfs_pkg::mdu_rsp_t rsp
);
	import pwfs_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [DIVISOR_W:0]     rem_q;
	logic [MDU_A_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0]   divisor_q;
	logic [MDU_A_W-1:0]     res_q;

	logic [DIVISOR_W:0]     rem_nxt;
	logic [MDU_A_W-1:0]     quo_nxt;
	logic [MDU_A_W-1:0]     product;
	logic                   last_step;

	assign product   = MDU_A_W'(req.a[MUL_W-1:0]) * MDU_A_W'(req.b[MUL_W-1:0]);
	assign last_step = (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));

	// restoring division, dividend shifts out of the top of the quotient register
	always_comb begin
		logic [DIVISOR_W:0]   r;
		logic [MDU_A_W-1:0]   q;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			r = {r[DIVISOR_W-1:0], q[MDU_A_W-1]};
			q = {q[MDU_A_W-2:0], 1'b0};
			if (r >= {1'b0, divisor_q}) begin
				r    = r - {1'b0, divisor_q};
				q[0] = 1'b1;
			end
		end
		rem_nxt = r;
		quo_nxt = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				unique case (req.op)
					MDU_MUL: begin
						done_q <= 1'b1;
					end
					MDU_DIV: begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end
					default: begin
						done_q <= 1'b0;
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			res_q     <= product;
			quo_q     <= req.a;
			rem_q     <= '0;
			divisor_q <= req.b[DIVISOR_W-1:0];
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
			if (last_step) begin
				res_q <= quo_nxt;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

@@ hdl/pwfs_seq.sv @@
// pwfs_seq: sequencer and datapath registers for the pid steering step
// drives the shared unit in pwfs_mdu for pid products and every quotient; uses pwfs_pkg and the channel interfaces
`timescale 1ns / 1ps

module pwfs_seq #(
	parameter int unsigned TICK_MS     = pwfs_pkg::TICK_MS_DEF,
	parameter int unsigned SAMPLE_BITS = pwfs_pkg::SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pwfs_pkg::cfg_t     cfg,
	pwfs_in_if.sink            sample,
	pwfs_out_if.source         speed,
	output pwfs_pkg::mdu_req_t mdu_req,
	input  pwfs_pkg::mdu_rsp_t mdu_rsp
);
	import pwfs_pkg::*;

	localparam int unsigned SW = (SAMPLE_BITS < PROX_W) ? SAMPLE_BITS : PROX_W;
	localparam logic [PROX_W-1:0] SMASK = PROX_W'((32'd1 << SW) - 32'd1);

	seq_state_t state_q, state_nxt;
	logic       issued_q;

	// state kept across requests
	logic [ERR_W-1:0]   last_err_q;
	logic [INTEG_W-1:0] integ_q;

	// per-request working registers
	logic               right_q;
	logic [SUM_W-1:0]   sum_q;
	logic [ERR_W-1:0]   err_q;
	logic [63:0]        tmp_q;
	logic [31:0]        kt_q;
	logic [P_W-1:0]     p_q;
	logic [D_W-1:0]     d_q;
	logic [I_W-1:0]     i_q;
	logic [DS_W-1:0]    ds_q;
	logic [MAG8_W-1:0]  mag8_q;
	logic               neg_q;
	logic [BASE_W-1:0]  base_q;

	logic                      out_valid_q;
	logic signed [SPEED_W-1:0] left_q;
	logic signed [SPEED_W-1:0] right_speed_q;

	logic in_ready;
	logic op_state;
	logic load_out;
	logic in_accept;

	// weighted sample sum
	logic [PROX_W-1:0] prox [N_PROX];
	logic [SUM_W-1:0]  wsum;

	assign prox[0] = sample.prox_0 & SMASK;
	assign prox[1] = sample.prox_1 & SMASK;
	assign prox[2] = sample.prox_2 & SMASK;
	assign prox[3] = sample.prox_3 & SMASK;
	assign prox[4] = sample.prox_4 & SMASK;
	assign prox[5] = sample.prox_5 & SMASK;
	assign prox[6] = sample.prox_6 & SMASK;
	assign prox[7] = sample.prox_7 & SMASK;

	always_comb begin
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < N_PROX; i++) begin
			acc = acc + SUM_W'(sample.wall_side ? W_RIGHT[i] : W_LEFT[i]) * SUM_W'(prox[i]);
		end
		wsum = acc;
	end

	// magnitudes and signs of the working values
	logic [ERR_W-1:0]   err_neg;
	logic [ERR_W-2:0]   emag;
	logic [ERR_W:0]     diff;
	logic [ERR_W:0]     diff_neg;
	logic [ERR_W-1:0]   dmag;
	logic [INTEG_W-1:0] integ_neg;
	logic [INTEG_W-1:0] imag;

	assign err_neg   = -err_q;
	assign emag      = err_q[ERR_W-1] ? err_neg[ERR_W-2:0] : err_q[ERR_W-2:0];
	assign diff      = {err_q[ERR_W-1], err_q} - {last_err_q[ERR_W-1], last_err_q};
	assign diff_neg  = -diff;
	assign dmag      = diff[ERR_W] ? diff_neg[ERR_W-1:0] : diff[ERR_W-1:0];
	assign integ_neg = -integ_q;
	// the most negative integral reads back as its own magnitude
	assign imag      = integ_q[INTEG_W-1] ? integ_neg : integ_q;

	// error from the rounded average
	logic [ERR_W+1:0] err_full;
	assign err_full = {2'b00, mdu_rsp.res[ERR_W-1:0]}
		- {3'b000, cfg.distance_target, 8'h00};

	// integral update with saturation
	logic [INTEG_W:0] inc_ext;
	logic [INTEG_W:0] integ_sum;
	logic [INTEG_W-1:0] integ_sat;

	assign inc_ext   = err_q[ERR_W-1] ? -(INTEG_W+1)'(mdu_rsp.res[ERR_W-2:0])
		: (INTEG_W+1)'(mdu_rsp.res[ERR_W-2:0]);
	assign integ_sum = {integ_q[INTEG_W-1], integ_q} + inc_ext;

	always_comb begin
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
				: {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_sat = integ_sum[INTEG_W-1:0];
		end
	end

	// clamped products
	logic [63:0] d_prod_clamp;
	logic [63:0] i_prod;
	logic [63:0] i_prod_clamp;

	assign d_prod_clamp = (mdu_rsp.res > PROD_LIMIT) ? PROD_LIMIT : mdu_rsp.res;
	assign i_prod       = (64'(mdu_rsp.res[P_W-1:0]) << 20) + tmp_q;
	assign i_prod_clamp = (i_prod > PROD_LIMIT) ? PROD_LIMIT : i_prod;

	// signed terms of the sum
	logic [DS_W-1:0] p_term;
	logic [DS_W-1:0] d_term;
	logic [DS_W-1:0] i_term;
	logic [DS_W-1:0] ds_abs;

	assign p_term = err_q[ERR_W-1] ? -DS_W'(p_q) : DS_W'(p_q);
	assign d_term = diff[ERR_W] ? -DS_W'(d_q) : DS_W'(d_q);
	assign i_term = integ_q[INTEG_W-1] ? -DS_W'(i_q) : DS_W'(i_q);
	assign ds_abs = ds_q[DS_W-1] ? -ds_q : ds_q;

	logic [17:0] base_full;
	assign base_full = 18'(cfg.speed_multiplier) * 18'(BASE_MUL);

	// final speeds
	logic [OUTS_W-1:0] spd_add;
	logic [OUTS_W-1:0] spd_sub;

	assign spd_add = OUTS_W'(base_q) + OUTS_W'(mag8_q);
	assign spd_sub = OUTS_W'(base_q) - OUTS_W'(mag8_q);

	function automatic logic [SPEED_W-1:0] sat16(input logic [OUTS_W-1:0] v);
		logic [OUTS_W-SPEED_W:0] upper;
		upper = v[OUTS_W-1:SPEED_W-1];
		if (!v[OUTS_W-1] && (upper != '0)) begin
			return {1'b0, {(SPEED_W-1){1'b1}}};
		end else if (v[OUTS_W-1] && (upper != '1)) begin
			return {1'b1, {(SPEED_W-1){1'b0}}};
		end
		return v[SPEED_W-1:0];
	endfunction

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_nxt = ST_AVG;
			end
			ST_AVG: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_INC_MUL;
			end
			ST_INC_MUL: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_INC_DIV;
			end
			ST_INC_DIV: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_P;
			end
			ST_P: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_D_SCALE;
			end
			ST_D_SCALE: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_D_GAIN;
			end
			ST_D_GAIN: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_D_MUL;
			end
			ST_D_MUL: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_D_DIV;
			end
			ST_D_DIV: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_I_LO;
			end
			ST_I_LO: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_I_HI;
			end
			ST_I_HI: begin
				// integral action is off with a zero integral time
				if (issued_q && mdu_rsp.done) begin
					state_nxt = (cfg.integral_time == '0) ? ST_SUM_PD : ST_I_DIV;
				end
			end
			ST_I_DIV: begin
				if (issued_q && mdu_rsp.done) state_nxt = ST_SUM_PD;
			end
			ST_SUM_PD: state_nxt = ST_SUM_I;
			ST_SUM_I:  state_nxt = ST_SCALE;
			ST_SCALE:  state_nxt = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || speed.ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs and unit operands
	always_comb begin
		in_ready    = 1'b0;
		load_out    = 1'b0;
		op_state    = 1'b1;
		mdu_req.op  = MDU_MUL;
		mdu_req.a   = '0;
		mdu_req.b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				op_state = 1'b0;
				in_ready = 1'b1;
			end
			ST_AVG: begin
				mdu_req.op = MDU_DIV;
				mdu_req.a  = MDU_A_W'({sum_q, 8'h00}) + MDU_A_W'(AVG_ROUND);
				mdu_req.b  = MDU_B_W'(WEIGHT_SUM);
			end
			ST_INC_MUL: begin
				mdu_req.a = MDU_A_W'(emag);
				mdu_req.b = MDU_B_W'(TICK_MS);
			end
			ST_INC_DIV: begin
				mdu_req.op = MDU_DIV;
				mdu_req.a  = tmp_q;
				mdu_req.b  = MDU_B_W'(MS_PER_S);
			end
			ST_P: begin
				mdu_req.a = MDU_A_W'(emag);
				mdu_req.b = MDU_B_W'(cfg.gain_k);
			end
			ST_D_SCALE: begin
				mdu_req.a = MDU_A_W'(dmag);
				mdu_req.b = MDU_B_W'(MS_PER_S);
			end
			ST_D_GAIN: begin
				mdu_req.a = MDU_A_W'(cfg.gain_k);
				mdu_req.b = MDU_B_W'(cfg.derivative_time);
			end
			ST_D_MUL: begin
				mdu_req.a = MDU_A_W'(kt_q);
				mdu_req.b = tmp_q[MDU_B_W-1:0];
			end
			ST_D_DIV: begin
				mdu_req.op = MDU_DIV;
				mdu_req.a  = tmp_q;
				mdu_req.b  = MDU_B_W'(TICK_MS);
			end
			ST_I_LO: begin
				mdu_req.a = MDU_A_W'(cfg.gain_k);
				mdu_req.b = MDU_B_W'(imag[19:0]);
			end
			ST_I_HI: begin
				mdu_req.a = MDU_A_W'(cfg.gain_k);
				mdu_req.b = MDU_B_W'(imag[INTEG_W-1:20]);
			end
			ST_I_DIV: begin
				mdu_req.op = MDU_DIV;
				mdu_req.a  = tmp_q;
				mdu_req.b  = MDU_B_W'(cfg.integral_time);
			end
			ST_SUM_PD, ST_SUM_I, ST_SCALE: begin
				op_state = 1'b0;
			end
			ST_OUT: begin
				op_state = 1'b0;
				load_out = !out_valid_q || speed.ready;
			end
			default: begin
				op_state = 1'b0;
			end
		endcase
		mdu_req.start = op_state && !issued_q;
	end

	assign in_accept    = sample.valid && in_ready;
	assign sample.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			last_err_q  <= '0;
			integ_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (mdu_req.start) begin
				issued_q <= 1'b1;
			end else if (mdu_rsp.done) begin
				issued_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				last_err_q  <= err_q;
			end else if (speed.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_INC_DIV && issued_q && mdu_rsp.done) begin
				integ_q <= integ_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sum_q   <= wsum;
			right_q <= sample.wall_side;
		end
		if (issued_q && mdu_rsp.done) begin
			unique case (state_q)
				ST_AVG:     err_q <= err_full[ERR_W-1:0];
				ST_INC_MUL: tmp_q <= mdu_rsp.res;
				ST_P:       p_q   <= mdu_rsp.res[P_W-1:0];
				ST_D_SCALE: tmp_q <= mdu_rsp.res;
				ST_D_GAIN:  kt_q  <= mdu_rsp.res[31:0];
				ST_D_MUL:   tmp_q <= 64'(d_prod_clamp[52:8]);
				ST_D_DIV:   d_q   <= mdu_rsp.res[D_W-1:0];
				ST_I_LO:    tmp_q <= mdu_rsp.res;
				ST_I_HI: begin
					tmp_q <= i_prod_clamp << 8;
					i_q   <= '0;
				end
				ST_I_DIV:   i_q   <= mdu_rsp.res[I_W-1:0];
				default:    tmp_q <= tmp_q;
			endcase
		end
		if (state_q == ST_SUM_PD) begin
			ds_q <= p_term + d_term;
		end
		if (state_q == ST_SUM_I) begin
			ds_q <= ds_q + i_term;
		end
		if (state_q == ST_SCALE) begin
			// steering flips for the left wall; truncation is on the magnitude
			mag8_q <= ds_abs[DS_W-1:12];
			neg_q  <= ds_q[DS_W-1] ^ !right_q;
			base_q <= (ds_abs > DS_LIMIT) ? '0 : base_full[17:4];
		end
		if (load_out) begin
			right_speed_q <= sat16(neg_q ? spd_sub : spd_add);
			left_q        <= sat16(neg_q ? spd_add : spd_sub);
		end
	end

	assign speed.valid       = out_valid_q;
	assign speed.left_speed  = left_q;
	assign speed.right_speed = right_speed_q;

endmodule

@@ hdl/pid_wall_follow_steer.sv @@
// channel  | dir | handshake     | payload
// sample   | in  | valid / ready | prox_0..prox_7 (12 bit), wall_side
// speed    | out | valid / ready | left_speed, right_speed (signed q8.8)
// cfg      | in  | cfg_wen       | cfg_index, cfg_data
//
// a request is worked through in sequence on the shared multiply / divide unit: four
// divides, three with a zero integral time, and the multiplies, one operation at a time;
// a divide takes longer than a multiply.
// reset clears the integral, the previous error and loads register defaults.
// a result waits in the output register; the next request is taken meanwhile,
// and the sequencer holds its last step until that register is free.
//
// pid_wall_follow_steer: top level, configuration registers and the two units
// depends on pwfs_pkg, pwfs_in_if, pwfs_out_if, pwfs_mdu and pwfs_seq
`timescale 1ns / 1ps

module pid_wall_follow_steer #(
	parameter int unsigned TICK_MS     = pwfs_pkg::TICK_MS_DEF,
	parameter int unsigned SAMPLE_BITS = pwfs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pwfs_in_if.sink                         sample,
	pwfs_out_if.source                      speed,
	input  logic                            cfg_wen,
	input  logic [pwfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwfs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pwfs_pkg::*;

	cfg_t     cfg_q;
	mdu_req_t mdu_req;
	mdu_rsp_t mdu_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_k           <= GAIN_K_RST;
			cfg_q.integral_time    <= INTEGRAL_TIME_RST;
			cfg_q.derivative_time  <= DERIVATIVE_TIME_RST;
			cfg_q.speed_multiplier <= SPEED_MULTIPLIER_RST;
			cfg_q.distance_target  <= DISTANCE_TARGET_RST;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_K:           cfg_q.gain_k           <= cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_TIME:    cfg_q.integral_time    <= cfg_data[TIME_W-1:0];
				REG_DERIVATIVE_TIME:  cfg_q.derivative_time  <= cfg_data[TIME_W-1:0];
				REG_SPEED_MULTIPLIER: cfg_q.speed_multiplier <= cfg_data[GAIN_W-1:0];
				REG_DISTANCE_TARGET:  cfg_q.distance_target  <= cfg_data[TARGET_W-1:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	pwfs_seq #(
		.TICK_MS     (TICK_MS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.sample  (sample),
		.speed   (speed),
		.mdu_req (mdu_req),
		.mdu_rsp (mdu_rsp)
	);

	pwfs_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.rsp    (mdu_rsp)
	);

endmodule

@@ tb/pwfs_steer_checker.sv @@
// pwfs_steer_checker: watches the sample, speed and cfg ports of the steering block,
// predicts each speed pair from the accepted samples and compares field by field
// depends on pwfs_pkg, pwfs_in_if and pwfs_out_if
`timescale 1ns / 1ps

module pwfs_steer_checker #(
	parameter int unsigned TICK_MS     = pwfs_pkg::TICK_MS_DEF,
	parameter int unsigned SAMPLE_BITS = pwfs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pwfs_in_if                              sample,
	pwfs_out_if                             speed,
	input  logic                            cfg_wen,
	input  logic [pwfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwfs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              speeds_outstanding
);
	import pwfs_pkg::*;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left;
		logic signed [SPEED_W-1:0] right;
	} speed_pair_t;

	localparam longint unsigned MAG_CAP  = 64'd1 << 52;
	localparam longint unsigned TURN_CAP = 64'd1 << 20;
	localparam longint          INTEG_HI = (64'sd1 <<< 39) - 64'sd1;
	localparam longint          INTEG_LO = -(64'sd1 <<< 39);
	localparam longint          TICK     = longint'(TICK_MS);
	localparam longint          MS_S     = 64'sd1000;

	localparam int unsigned LEFT_WEIGHT  [N_PROX] = '{0, 0, 0, 0, 0, 1, 1, 3};
	localparam int unsigned RIGHT_WEIGHT [N_PROX] = '{3, 1, 1, 0, 0, 0, 0, 0};

	logic [GAIN_W-1:0]   gain_k;
	logic [TIME_W-1:0]   integ_time;
	logic [TIME_W-1:0]   deriv_time;
	logic [GAIN_W-1:0]   speed_mult;
	logic [TARGET_W-1:0] dist_target;
	longint              prev_error;
	longint              error_sum;

	speed_pair_t         speeds_due [$];
	speed_pair_t         got, want;
	logic [PROX_W-1:0]   seen_prox [N_PROX];

	function automatic longint unsigned magnitude(input longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// product whose magnitude is capped at 2^52
	function automatic longint capped_product(input longint a, input longint b);
		longint unsigned ua, ub, m;
		ua = magnitude(a);
		ub = magnitude(b);
		if (ua == 0 || ub == 0)
			return 0;
		if (ua > MAG_CAP / ub)
			m = MAG_CAP;
		else
			m = ua * ub;
		if (m > MAG_CAP)
			m = MAG_CAP;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [SPEED_W-1:0] clip_speed(input longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[SPEED_W-1:0];
	endfunction

	// one control tick: predicts the speed pair and updates the error history and integral
	function automatic speed_pair_t steer_predict(input logic [PROX_W-1:0] prox [N_PROX],
			input logic right_wall);
		longint unsigned wsum, smask, w;
		longint avg, err, diff, integ, k, p, dnum, d, it, ds, base, ds8;
		speed_pair_t r;
		smask = (64'd1 << SAMPLE_BITS) - 64'd1;
		wsum = 0;
		for (int i = 0; i < N_PROX; i++) begin
			w = right_wall ? RIGHT_WEIGHT[i] : LEFT_WEIGHT[i];
			wsum += w * (longint'(prox[i]) & smask);
		end
		avg  = longint'((wsum * 256 + 2) / 5);
		err  = avg - longint'(dist_target) * 256;
		diff = err - prev_error;

		integ = error_sum + (err * TICK) / MS_S;
		if (integ > INTEG_HI)
			integ = INTEG_HI;
		if (integ < INTEG_LO)
			integ = INTEG_LO;
		error_sum  = integ;
		prev_error = err;

		k    = longint'(gain_k);
		p    = k * err;
		dnum = capped_product(capped_product(k * longint'(deriv_time), diff), MS_S);
		d    = dnum / (256 * TICK);
		it   = 0;
		// zero integral time turns integral action off, the sum still runs
		if (integ_time != 0)
			it = capped_product(k, integ) * 256 / longint'(integ_time);

		ds = p + d + it;
		if (!right_wall)
			ds = -ds;
		base = (longint'(speed_mult) * 3) >>> 4;
		if (magnitude(ds) > TURN_CAP)
			base = 0;
		ds8 = ds / 4096;
		r.left  = clip_speed(base - ds8);
		r.right = clip_speed(base + ds8);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_k             = 16'd0;
			integ_time         = 16'd256;
			deriv_time         = 16'd0;
			speed_mult         = 16'd4096;
			dist_target        = 12'd700;
			prev_error         = 0;
			error_sum          = 0;
			mismatches         = 0;
			speeds_outstanding = 0;
			speeds_due.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_GAIN_K:           gain_k      = cfg_data[GAIN_W-1:0];
					REG_INTEGRAL_TIME:    integ_time  = cfg_data[TIME_W-1:0];
					REG_DERIVATIVE_TIME:  deriv_time  = cfg_data[TIME_W-1:0];
					REG_SPEED_MULTIPLIER: speed_mult  = cfg_data[GAIN_W-1:0];
					REG_DISTANCE_TARGET:  dist_target = cfg_data[TARGET_W-1:0];
					default: ;
				endcase
			end
			if (sample.valid && sample.ready) begin
				seen_prox[0] = sample.prox_0;
				seen_prox[1] = sample.prox_1;
				seen_prox[2] = sample.prox_2;
				seen_prox[3] = sample.prox_3;
				seen_prox[4] = sample.prox_4;
				seen_prox[5] = sample.prox_5;
				seen_prox[6] = sample.prox_6;
				seen_prox[7] = sample.prox_7;
				speeds_due.push_back(steer_predict(seen_prox, sample.wall_side));
			end
			if (speed.valid && speed.ready) begin
				got.left  = speed.left_speed;
				got.right = speed.right_speed;
				if (speeds_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected speed pair left %0d right %0d", $realtime,
							got.left, got.right);
					mismatches++;
				end else begin
					want = speeds_due.pop_front();
					if (got.left !== want.left || got.right !== want.right) begin
						if (mismatches < 10)
							$display("%0t: speed mismatch: left exp %0d got %0d, right exp %0d got %0d",
								$realtime, want.left, got.left, want.right, got.right);
						mismatches++;
					end
				end
			end
			speeds_outstanding = speeds_due.size();
		end
	end

endmodule

@@ tb/tb_pid_wall_follow_steer.sv @@
// tb_pid_wall_follow_steer: clock, reset, register writes and sample requests
// for the wall-follow steering block; checking is done by pwfs_steer_checker
// depends on pwfs_pkg, pwfs_in_if, pwfs_out_if, pid_wall_follow_steer, pwfs_steer_checker
`timescale 1ns / 1ps

module tb_pid_wall_follow_steer;
	import pwfs_pkg::*;

	localparam int unsigned TICK_MS     = TICK_MS_DEF;
	localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int          N_PHASES    = 8;
	localparam int          PHASE_ITEMS = 170;
	localparam int          SETTLE      = 120;
	localparam int          LONG_HOLD   = 400;

	typedef logic [N_PROX-1:0][PROX_W-1:0] prox_vec_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    speeds_outstanding;
	logic [TARGET_W-1:0]   cur_target;
	bit                    calm;
	bit                    long_hold_req;

	pwfs_in_if  sample_ch ();
	pwfs_out_if speed_ch ();

	pid_wall_follow_steer #(
		.TICK_MS     (TICK_MS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.speed     (speed_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pwfs_steer_checker #(
		.TICK_MS     (TICK_MS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.sample             (sample_ch),
		.speed              (speed_ch),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mismatches         (mismatches),
		.speeds_outstanding (speeds_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	task automatic write_all(input logic [15:0] k, input logic [15:0] ti, input logic [15:0] td,
			input logic [15:0] sm, input logic [11:0] tgt);
		write_reg(REG_GAIN_K, k);
		write_reg(REG_INTEGRAL_TIME, ti);
		write_reg(REG_DERIVATIVE_TIME, td);
		write_reg(REG_SPEED_MULTIPLIER, sm);
		write_reg(REG_DISTANCE_TARGET, {4'd0, tgt});
		cur_target = tgt;
	endtask

	// stop offering, wait for every result, then let the sequencer go quiet
	task automatic drain();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (speeds_outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_sample(input prox_vec_t prox, input logic side);
		int gap;
		if (!calm && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			sample_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_ch.prox_0    = prox[0];
		sample_ch.prox_1    = prox[1];
		sample_ch.prox_2    = prox[2];
		sample_ch.prox_3    = prox[3];
		sample_ch.prox_4    = prox[4];
		sample_ch.prox_5    = prox[5];
		sample_ch.prox_6    = prox[6];
		sample_ch.prox_7    = prox[7];
		sample_ch.wall_side = side;
		sample_ch.valid     = 1'b1;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	function automatic prox_vec_t all_same(input logic [PROX_W-1:0] v);
		prox_vec_t p;
		for (int i = 0; i < N_PROX; i++)
			p[i] = v;
		return p;
	endfunction

	// mostly readings close to the target so the loop stays out of saturation
	function automatic prox_vec_t random_readings(input logic [TARGET_W-1:0] tgt);
		prox_vec_t p;
		int mode, v, hot;
		mode = $urandom_range(0, 9);
		hot  = $urandom_range(0, N_PROX - 1);
		for (int i = 0; i < N_PROX; i++) begin
			v = int'(tgt) + int'($urandom_range(0, 8)) - 4;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			case (mode)
				6, 7: p[i] = 12'($urandom_range(0, 4095));
				8:    p[i] = $urandom_range(0, 1) ? 12'hfff : 12'h000;
				9:    p[i] = (i == hot) ? 12'($urandom_range(0, 4095)) : 12'(v);
				default: p[i] = 12'(v);
			endcase
		end
		return p;
	endfunction

	// receiver: short stall bursts, quiet stretches and one long hold-off
	initial begin
		int r;
		speed_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (long_hold_req) begin
				long_hold_req  = 1'b0;
				speed_ch.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && r < 8) begin
				speed_ch.ready = 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else if (r < 12) begin
				speed_ch.ready = 1'b1;
				repeat ($urandom_range(30, 80)) @(negedge clk);
			end else begin
				speed_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		prox_vec_t pv;
		logic [15:0] k, ti, td, sm;
		logic [11:0] tgt;
		arst_n              = 1'b0;
		cfg_wen             = 1'b0;
		cfg_index           = REG_GAIN_K;
		cfg_data            = '0;
		calm                = 1'b0;
		long_hold_req       = 1'b0;
		cur_target          = 12'd700;
		sample_ch.valid     = 1'b0;
		sample_ch.prox_0    = '0;
		sample_ch.prox_1    = '0;
		sample_ch.prox_2    = '0;
		sample_ch.prox_3    = '0;
		sample_ch.prox_4    = '0;
		sample_ch.prox_5    = '0;
		sample_ch.prox_6    = '0;
		sample_ch.prox_7    = '0;
		sample_ch.wall_side = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: register defaults first
		send_sample(all_same(12'h000), 1'b0);
		send_sample(all_same(12'hfff), 1'b1);
		drain();

		write_all(16'd32, 16'd256, 16'd256, 16'd4096, 12'd700);
		send_sample(all_same(12'd700), 1'b1);
		send_sample(all_same(12'd700), 1'b0);
		send_sample(all_same(12'd701), 1'b1);
		send_sample(all_same(12'd699), 1'b0);
		send_sample(all_same(12'h000), 1'b1);
		send_sample(all_same(12'hfff), 1'b0);
		// one hot sensor at a time: 0..3 on the right wall, 4..7 on the left, where 3 and 4 weigh nothing
		for (int i = 0; i < N_PROX; i++) begin
			pv = all_same(12'd700);
			pv[i] = 12'hfff;
			send_sample(pv, (i < 4) ? 1'b1 : 1'b0);
		end
		send_sample(all_same(12'haaa), 1'b1);
		send_sample(all_same(12'h555), 1'b0);
		drain();

		// huge gain and derivative time with a full-scale swing hit the product cap
		write_all(16'hffff, 16'd1, 16'hffff, 16'hffff, 12'd0);
		send_sample(all_same(12'h000), 1'b1);
		send_sample(all_same(12'hfff), 1'b1);
		send_sample(all_same(12'h000), 1'b0);
		drain();

		// integral action off
		write_all(16'd8, 16'd0, 16'd16, 16'd2048, 12'd1500);
		send_sample(all_same(12'd1510), 1'b1);
		send_sample(all_same(12'd1490), 1'b0);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin
					k = 16'hffff; ti = 16'hffff; td = 16'hffff; sm = 16'hffff; tgt = 12'hfff;
				end
				1: begin
					k = 16'd0; ti = 16'd1; td = 16'd0; sm = 16'd0; tgt = 12'd0;
				end
				2: begin
					k = 16'($urandom_range(1, 64)); ti = 16'd0;
					td = 16'($urandom_range(0, 4096));
					sm = 16'($urandom_range(0, 65535)); tgt = 12'($urandom_range(0, 4095));
				end
				default: begin
					k  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 256));
					ti = 16'($urandom_range(1, 65535));
					td = 16'($urandom_range(0, 4096));
					sm = 16'($urandom_range(0, 65535));
					tgt = 12'($urandom_range(0, 4095));
				end
			endcase
			write_all(k, ti, td, sm, tgt);
			if (ph == 0)
				long_hold_req = 1'b1;
			if (ph == N_PHASES - 1)
				calm = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(random_readings(cur_target), 1'($urandom_range(0, 1)));
			drain();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ pid_wall_follow_steer.f @@
hdl/pwfs_pkg.sv
hdl/pwfs_in_if.sv
hdl/pwfs_out_if.sv
hdl/pwfs_mdu.sv
hdl/pwfs_seq.sv
hdl/pid_wall_follow_steer.sv
tb/pwfs_steer_checker.sv
tb/tb_pid_wall_follow_steer.sv
